@@ rtl/stdr_pkg.sv @@
`default_nettype none

package stdr_pkg;

  localparam int SET_CAPACITY = 1024;
  localparam int ADDR_BITS    = $clog2(SET_CAPACITY);
  localparam int CNT_BITS     = ADDR_BITS + 1;
  localparam int TASK_ID_BITS = 22;

  localparam logic [31:0] FAST_SLICE_RESET = 32'd50000000;

  // register index as decoded from paddr[2]
  localparam logic REG_FAST_SLICE = 1'b0;

  localparam logic KIND_ROUTE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef logic [ADDR_BITS-1:0]    addr_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [TASK_ID_BITS-1:0] id_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } set_state_t;

  typedef struct packed {
    id_t  id;
    logic insert;
  } set_req_t;

  typedef struct packed {
    logic member;
    logic demoted;
    logic full;
  } set_rsp_t;

  // xor fold of the id into a bucket index, kept below the capacity
  function automatic addr_t hash_id(input id_t id);
    addr_t h;
    h = '0;
    for (int i = 0; i < TASK_ID_BITS; i++) begin
      h[i % ADDR_BITS] = h[i % ADDR_BITS] ^ id[i];
    end
    if (h > addr_t'(SET_CAPACITY - 1)) begin
      h = h - addr_t'(SET_CAPACITY);
    end
    return h;
  endfunction

endpackage

`default_nettype wire

@@ rtl/slow_task_demotion_router_core.sv @@
`default_nettype none

// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        tdata task_id, slice_exhausted, random_bit; tuser kind
// m_*       out  m_tvalid / m_tready        tdata target_cpu .. set_full
// apb       in   psel, penable, pready=1    fast_slice_ns at byte address 0
//
// an item is decided in the first bucket of its hash chain or moves on by linear probing;
// each probe is a registered read, then a compare, on the single set memory port,
// so a miss in a full set probes all 1024 buckets before its result is ready.
// after reset a clearing pass writes all 1024 entries, one per cycle, with s_tready low.
// one item is in work at a time; its result waits in the engine while m_tvalid is held
// by a stalled consumer, and the output register keeps the previous result meanwhile.

module slow_task_demotion_router_core
  import stdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [21:0] task_id, [22] slice_exhausted, [23] random_bit
  input  wire logic [23:0] s_tdata,
  // [0] kind
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] target_cpu, [2] unlimited_slice, [34:3] slice_length, [35] is_slow,
  // [36] demoted, [37] set_full, [39:38] zero
  output logic [39:0]      m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] fast_slice_ns;
  logic        kind_q;
  logic        rnd_q;

  logic      eng_idle;
  logic      eng_done;
  logic      rsp_ready;
  set_req_t  eng_req;
  set_rsp_t  eng_rsp;
  logic      s_fire;

  logic [1:0]  target_cpu;
  logic        unlimited_slice;
  logic [31:0] slice_length;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FAST_SLICE) ? fast_slice_ns : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_slice_ns <= FAST_SLICE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FAST_SLICE) begin
      fast_slice_ns <= pwdata;
    end
  end

  assign s_tready       = eng_idle;
  assign s_fire         = s_tvalid && s_tready;
  assign eng_req.id     = s_tdata[TASK_ID_BITS-1:0];
  assign eng_req.insert = (s_tuser == KIND_TICK) && s_tdata[22];
  assign rsp_ready      = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (s_fire) begin
      kind_q <= s_tuser;
      rnd_q  <= s_tdata[23];
    end
  end

  stdr_set u_set (
    .clk       (clk),
    .rst       (rst),
    .start     (s_fire),
    .req       (eng_req),
    .rsp_ready (rsp_ready),
    .idle      (eng_idle),
    .done      (eng_done),
    .rsp       (eng_rsp)
  );

  always_comb begin
    target_cpu      = 2'd0;
    unlimited_slice = 1'b0;
    slice_length    = 32'd0;
    if (kind_q == KIND_ROUTE) begin
      if (eng_rsp.member) begin
        target_cpu      = {1'b0, rnd_q};
        unlimited_slice = 1'b1;
      end else begin
        target_cpu   = {1'b1, rnd_q};
        slice_length = fast_slice_ns;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eng_done && rsp_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done && rsp_ready) begin
      m_tdata <= {2'b00, eng_rsp.full, eng_rsp.demoted, eng_rsp.member,
                  slice_length, unlimited_slice, target_cpu};
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("engine still takes requests after accepting one");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[36] && m_tdata[37]))
    else $error("demoted and set_full both set");

  a_unlimited_is_slow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[35] && m_tdata[34:3] == 32'd0 && !m_tdata[1])
    else $error("unlimited slice on a task outside the slow set");

  a_tick_no_route: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[36] || m_tdata[37]) |-> m_tdata[34:0] == 35'd0 && !m_tdata[35])
    else $error("tick result carries route fields");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("channel active right after reset");

endmodule

`default_nettype wire

@@ rtl/stdr_set.sv @@
`default_nettype none

module stdr_set
  import stdr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire set_req_t req,
  input  wire logic     rsp_ready,
  output logic          idle,
  output logic          done,
  output set_rsp_t      rsp
);

  // entry: {valid, id}
  logic [TASK_ID_BITS:0] mem [SET_CAPACITY];
  logic [TASK_ID_BITS:0] rd_data;

  set_state_t state;
  set_state_t state_next;

  set_req_t req_q;
  addr_t    clr_addr;
  addr_t    probe_addr;
  addr_t    probe_cnt;
  cnt_t     member_count;

  logic                  rd_en;
  logic                  wr_en;
  addr_t                 wr_addr;
  logic [TASK_ID_BITS:0] wr_data;

  logic hit;
  logic empty;
  logic last_probe;
  logic insert_now;
  logic clr_last;
  addr_t probe_addr_inc;

  assign hit        = rd_data[TASK_ID_BITS] && (rd_data[TASK_ID_BITS-1:0] == req_q.id);
  assign empty      = !rd_data[TASK_ID_BITS];
  assign last_probe = probe_cnt == addr_t'(SET_CAPACITY - 1);
  assign clr_last   = clr_addr == addr_t'(SET_CAPACITY - 1);
  assign insert_now = req_q.insert && !hit && empty && (member_count != cnt_t'(SET_CAPACITY));
  assign probe_addr_inc = (probe_addr == addr_t'(SET_CAPACITY - 1)) ? '0 : probe_addr + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (hit || empty || last_probe) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_DONE:  if (rsp_ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    idle    = 1'b0;
    done    = 1'b0;
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = probe_addr;
    wr_data = {1'b1, req_q.id};
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      ST_IDLE:  idle = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_CHECK: wr_en = insert_now;
      ST_DONE:  done = 1'b1;
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[probe_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      member_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (wr_en && state == ST_CHECK) begin
        member_count <= member_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_q      <= req;
      probe_addr <= hash_id(req.id);
      probe_cnt  <= '0;
    end else if (state == ST_CHECK) begin
      if (hit || empty || last_probe) begin
        rsp.member  <= hit;
        rsp.demoted <= insert_now;
        // no free slot anywhere along the chain
        rsp.full    <= req_q.insert && !hit && !insert_now;
      end else begin
        probe_addr <= probe_addr_inc;
        probe_cnt  <= probe_cnt + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
